### hdl/tick_timebase_cpu_usage_defines.svh
// ----------------------------------------------------------------------------
// Tick time base assertion macros
// Shared property macros for the checker of the tick time base.
// ----------------------------------------------------------------------------
`ifndef TICK_TIMEBASE_CPU_USAGE_DEFINES_SVH
`define TICK_TIMEBASE_CPU_USAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ttcu_pkg.sv
// ----------------------------------------------------------------------------
// Tick time base package
// Types, codes and constants shared by the tick time base modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcu_pkg;

    localparam int CNT_W  = 32;  // tick and usage counters
    localparam int PCT_W  = 7;   // busy percentage
    localparam int OP_W   = 2;
    localparam int NUM_W  = CNT_W + PCT_W;  // scaled busy count
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_ANNOUNCE = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd2;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_USAGE_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

### hdl/ttcu_if.sv
// ----------------------------------------------------------------------------
// Tick time base channels
// Valid/ready channels for event requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcu_req_if;
    logic                           valid;
    logic                           ready;
    logic [ttcu_pkg::OP_W-1:0]      op;
    logic [ttcu_pkg::CNT_W-1:0]     slept_ticks;
    logic                           running_idle;
    logic                           from_owner_core;

    modport source (
        output valid, op, slept_ticks, running_idle, from_owner_core,
        input  ready
    );
    modport sink (
        input  valid, op, slept_ticks, running_idle, from_owner_core,
        output ready
    );
endinterface

interface ttcu_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ttcu_pkg::CNT_W-1:0]     tick_count;
    logic [ttcu_pkg::PCT_W-1:0]     busy_percent;

    modport source (
        output valid, tick_count, busy_percent,
        input  ready
    );
    modport sink (
        input  valid, tick_count, busy_percent,
        output ready
    );
endinterface

`default_nettype wire

### hdl/ttcu_div.sv
// ----------------------------------------------------------------------------
// Tick time base divider
// Restoring divider, one quotient bit per cycle, for the busy percentage.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcu_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ttcu_pkg::div_ctrl_t   ctrl,
    output      ttcu_pkg::div_stat_t   stat
);

    logic [ttcu_pkg::NUM_W-1:0]     dvd_reg, dvd_next;
    logic [ttcu_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [ttcu_pkg::CNT_W-1:0]     dvs_reg, dvs_next;
    logic [ttcu_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [ttcu_pkg::CNT_W:0]       rem_sh;
    logic                           fits;

    // The remainder stays below the divisor, so the shifted value fits in
    // one bit more than the counters.
    assign rem_sh = {rem_reg, dvd_reg[ttcu_pkg::NUM_W-1]};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            dvd_next = ctrl.dividend;
            rem_next = '0;
            dvs_next = ctrl.divisor;
            cnt_next = ttcu_pkg::DIV_CNT_W'(ttcu_pkg::NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? ttcu_pkg::CNT_W'(rem_sh - {1'b0, dvs_reg})
                            : ttcu_pkg::CNT_W'(rem_sh);
            dvd_next = {dvd_reg[ttcu_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == ttcu_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = dvd_reg[ttcu_pkg::PCT_W-1:0];

endmodule

`default_nettype wire

### hdl/tick_timebase_cpu_usage.sv
// ----------------------------------------------------------------------------
// Tick time base with CPU load accounting
// Tick counter with total and idle usage counters and a busy percentage.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result for
// it. Ticks, announces, unused codes and samples of an empty or disabled
// window pass through ST_EXEC and present their result in ST_DONE. A sample
// of a non-empty window with usage accounting on goes on from ST_EXEC through
// ST_MUL and a 39-step restoring divider in ST_DIV, one quotient bit per
// cycle, before its result is presented in ST_DONE. The request channel is
// ready again in the cycle after the result is taken. The usage_enable
// register sits at byte address 0 of the configuration port and resets to
// one.
`default_nettype none

module tick_timebase_cpu_usage (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ttcu_req_if.sink                               req,
    ttcu_rsp_if.source                             rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ttcu_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ttcu_pkg::CFG_DATA_W-1:0]   pwdata,
    output      logic [ttcu_pkg::CFG_DATA_W-1:0]   prdata,
    output      logic                              pready
);

    ttcu_pkg::state_t               state_reg, state_next;
    logic [ttcu_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ttcu_pkg::CNT_W-1:0]     elapsed_reg, elapsed_next;
    logic                           run_idle_reg, run_idle_next;
    logic                           owner_reg, owner_next;
    logic [ttcu_pkg::CNT_W-1:0]     ticks_reg, ticks_next;
    logic [ttcu_pkg::CNT_W-1:0]     total_reg, total_next;
    logic [ttcu_pkg::CNT_W-1:0]     idle_reg, idle_next;
    logic [ttcu_pkg::CNT_W-1:0]     busy_reg, busy_next;
    logic [ttcu_pkg::CNT_W-1:0]     divisor_reg, divisor_next;
    logic [ttcu_pkg::PCT_W-1:0]     pct_reg, pct_next;
    logic                           usage_en_reg, usage_en_next;
    logic                           cfg_wr;
    logic [ttcu_pkg::CNT_W-1:0]     idle_clamped;
    ttcu_pkg::div_ctrl_t            div_ctrl;
    ttcu_pkg::div_stat_t            div_stat;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == ttcu_pkg::ADDR_USAGE_ENABLE);
    assign usage_en_next = cfg_wr ? pwdata[0] : usage_en_reg;
    assign prdata = (paddr == ttcu_pkg::ADDR_USAGE_ENABLE)
                    ? {{(ttcu_pkg::CFG_DATA_W-1){1'b0}}, usage_en_reg} : '0;

    assign idle_clamped = (idle_reg > total_reg) ? total_reg : idle_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        elapsed_next  = elapsed_reg;
        run_idle_next = run_idle_reg;
        owner_next    = owner_reg;
        ticks_next    = ticks_reg;
        total_next    = total_reg;
        idle_next     = idle_reg;
        busy_next     = busy_reg;
        divisor_next  = divisor_reg;
        pct_next      = pct_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = ttcu_pkg::NUM_W'(busy_reg)
                            * ttcu_pkg::NUM_W'(ttcu_pkg::PCT_SCALE);
        div_ctrl.divisor  = divisor_reg;
        req.ready = 1'b0;
        rsp.valid = 1'b0;

        case (state_reg)
            ttcu_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next       = req.op;
                    elapsed_next  = req.slept_ticks;
                    run_idle_next = req.running_idle;
                    owner_next    = req.from_owner_core;
                    state_next    = ttcu_pkg::ST_EXEC;
                end
            end

            ttcu_pkg::ST_EXEC:
            begin
                pct_next   = '0;
                state_next = ttcu_pkg::ST_DONE;
                case (op_reg)
                    ttcu_pkg::OP_TICK:
                    begin
                        if (owner_reg)
                        begin
                            ticks_next = ticks_reg + 1'b1;
                            if (usage_en_reg)
                            begin
                                total_next = total_reg + 1'b1;
                                if (run_idle_reg)
                                begin
                                    idle_next = idle_reg + 1'b1;
                                end
                            end
                        end
                    end
                    ttcu_pkg::OP_ANNOUNCE:
                    begin
                        ticks_next = ticks_reg + elapsed_reg;
                        if (usage_en_reg)
                        begin
                            total_next = total_reg + elapsed_reg;
                            idle_next  = idle_reg + elapsed_reg;
                        end
                    end
                    ttcu_pkg::OP_SAMPLE:
                    begin
                        if (usage_en_reg)
                        begin
                            total_next = '0;
                            idle_next  = '0;
                            // An empty window reports zero without dividing.
                            if (total_reg != '0)
                            begin
                                busy_next    = total_reg - idle_clamped;
                                divisor_next = total_reg;
                                state_next   = ttcu_pkg::ST_MUL;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ttcu_pkg::ST_DONE;
                    end
                endcase
            end

            ttcu_pkg::ST_MUL:
            begin
                div_ctrl.start = 1'b1;
                state_next     = ttcu_pkg::ST_DIV;
            end

            ttcu_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    pct_next   = div_stat.quotient;
                    state_next = ttcu_pkg::ST_DONE;
                end
            end

            ttcu_pkg::ST_DONE:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = ttcu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ttcu_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.tick_count   = ticks_reg;
    assign rsp.busy_percent = pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ttcu_pkg::ST_IDLE;
            ticks_reg    <= '0;
            total_reg    <= '0;
            idle_reg     <= '0;
            usage_en_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            ticks_reg    <= ticks_next;
            total_reg    <= total_next;
            idle_reg     <= idle_next;
            usage_en_reg <= usage_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        elapsed_reg  <= elapsed_next;
        run_idle_reg <= run_idle_next;
        owner_reg    <= owner_next;
        busy_reg     <= busy_next;
        divisor_reg  <= divisor_next;
        pct_reg      <= pct_next;
    end

    ttcu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

endmodule

`default_nettype wire

### hdl/ttcu_checker.sv
// ----------------------------------------------------------------------------
// Tick time base checker
// Port-level checks on request and result ordering and on the result values,
// bound to the top level.
`default_nettype none
`include "tick_timebase_cpu_usage_defines.svh"

module ttcu_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [ttcu_pkg::CNT_W-1:0]    tick_count,
    input wire logic [ttcu_pkg::PCT_W-1:0]    busy_percent
);

    // Only one request is in flight at a time.
    `TTCU_ASSERT_NXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while another was in flight")

    `TTCU_ASSERT_IMP(a_no_overlap, clk, rst_n, rsp_valid, !req_ready, "ready for a request while a result is pending")

    `TTCU_ASSERT_NXT(a_ready_after_rsp, clk, rst_n, rsp_valid && rsp_ready, req_ready && !rsp_valid, "block not ready after its result was taken")

    `TTCU_ASSERT_IMP(a_pct_range, clk, rst_n, rsp_valid, busy_percent <= ttcu_pkg::PCT_SCALE, "busy percentage above one hundred")

    `TTCU_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(tick_count) && $stable(busy_percent), "stalled result changed")

endmodule

bind tick_timebase_cpu_usage ttcu_checker u_ttcu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .tick_count   (rsp.tick_count),
    .busy_percent (rsp.busy_percent)
);

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// Tick time base testbench
// Drives tick, announce, sample and unused event requests through the request
// channel and checks every result against a cycle-free model of the tick and
// usage counters, across both settings of usage_enable and several idling
// profiles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // The fourth op code has no meaning and must leave every counter alone.
    localparam logic [ttcu_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [ttcu_pkg::OP_W-1:0]  op;
        logic [ttcu_pkg::CNT_W-1:0] elapsed;
        logic                       running_idle;
        logic                       from_owner;
    } tick_event_t;

    typedef struct {
        logic [ttcu_pkg::CNT_W-1:0] tick_count;
        logic [ttcu_pkg::PCT_W-1:0] busy_percent;
    } usage_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ttcu_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ttcu_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ttcu_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    ttcu_req_if req_ch ();
    ttcu_rsp_if rsp_ch ();

    tick_timebase_cpu_usage u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tick_event_t   events_pending[$];
    usage_result_t results_due[$];
    tick_event_t   event_on_bus;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;

    // Shadow copy of the block's counters and its enable register.
    logic [ttcu_pkg::CNT_W-1:0] mdl_ticks;
    logic [ttcu_pkg::CNT_W-1:0] mdl_total;
    logic [ttcu_pkg::CNT_W-1:0] mdl_idle;
    logic                       mdl_usage_on;

    function automatic usage_result_t account_event(tick_event_t ev);
        usage_result_t     res;
        longint unsigned   total;
        longint unsigned   idle;
        begin
            res.busy_percent = '0;
            case (ev.op)
                ttcu_pkg::OP_TICK:
                begin
                    if (ev.from_owner)
                    begin
                        mdl_ticks = mdl_ticks + 1'b1;
                        if (mdl_usage_on)
                        begin
                            mdl_total = mdl_total + 1'b1;
                            if (ev.running_idle)
                                mdl_idle = mdl_idle + 1'b1;
                        end
                    end
                end
                ttcu_pkg::OP_ANNOUNCE:
                begin
                    mdl_ticks = mdl_ticks + ev.elapsed;
                    if (mdl_usage_on)
                    begin
                        mdl_total = mdl_total + ev.elapsed;
                        mdl_idle  = mdl_idle + ev.elapsed;
                    end
                end
                ttcu_pkg::OP_SAMPLE:
                begin
                    if (mdl_usage_on)
                    begin
                        total = mdl_total;
                        idle  = mdl_idle;
                        mdl_total = '0;
                        mdl_idle  = '0;
                        if (total != 0)
                        begin
                            // Idle can overtake total once the total count wraps.
                            if (idle > total)
                                idle = total;
                            res.busy_percent =
                                ttcu_pkg::PCT_W'(((total - idle) * 100) / total);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res.tick_count = mdl_ticks;
            return res;
        end
    endfunction

    // Request driver: holds a request until it is taken, then offers the next.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            if (req_ch.valid && req_ch.ready)
                results_due.push_back(account_event(event_on_bus));
            if (events_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                event_on_bus = events_pending.pop_front();
                req_ch.valid           <= 1'b1;
                req_ch.op              <= event_on_bus.op;
                req_ch.slept_ticks     <= event_on_bus.elapsed;
                req_ch.running_idle    <= event_on_bus.running_idle;
                req_ch.from_owner_core <= event_on_bus.from_owner;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with a randomly stalling receiver.
    always @(posedge clk)
    begin
        usage_result_t exp_res;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result with none due: tick_count %0d busy_percent %0d",
                             $time, rsp_ch.tick_count, rsp_ch.busy_percent);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = results_due.pop_front();
                    if (rsp_ch.tick_count !== exp_res.tick_count)
                    begin
                        $display("%0t: tick_count expected %0d actual %0d",
                                 $time, exp_res.tick_count, rsp_ch.tick_count);
                        mismatch_count++;
                    end
                    if (rsp_ch.busy_percent !== exp_res.busy_percent)
                    begin
                        $display("%0t: busy_percent expected %0d actual %0d",
                                 $time, exp_res.busy_percent, rsp_ch.busy_percent);
                        mismatch_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_event(logic [ttcu_pkg::OP_W-1:0] op,
                              logic [ttcu_pkg::CNT_W-1:0] elapsed,
                              logic running_idle, logic from_owner);
        tick_event_t ev;
        begin
            ev.op           = op;
            ev.elapsed      = elapsed;
            ev.running_idle = running_idle;
            ev.from_owner   = from_owner;
            events_pending.push_back(ev);
        end
    endtask

    task automatic push_random(int unsigned count);
        tick_event_t ev;
        int unsigned pick;
        begin
            repeat (count)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    ev.op = ttcu_pkg::OP_TICK;
                else if (pick < 72)
                    ev.op = ttcu_pkg::OP_ANNOUNCE;
                else if (pick < 93)
                    ev.op = ttcu_pkg::OP_SAMPLE;
                else
                    ev.op = OP_UNUSED;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: ev.elapsed = $urandom_range(0, 20);
                    5:             ev.elapsed = $urandom_range(0, 1000);
                    6, 7:          ev.elapsed = $urandom();
                    8:             ev.elapsed = '1;
                    default:       ev.elapsed = '0;
                endcase
                ev.running_idle = 1'($urandom_range(0, 1));
                ev.from_owner   = ($urandom_range(0, 9) != 0);
                events_pending.push_back(ev);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (events_pending.size() != 0 || req_ch.valid || results_due.size() != 0)
                @(posedge clk);
        end
    endtask

    // Two-phase register write; only called with nothing in flight.
    task automatic write_usage_enable(logic value);
        begin
            wait_drained();
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ttcu_pkg::ADDR_USAGE_ENABLE;
            pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), value};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            mdl_usage_on = value;
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        req_ch.valid           = 1'b0;
        req_ch.op              = ttcu_pkg::OP_TICK;
        req_ch.slept_ticks     = '0;
        req_ch.running_idle    = 1'b0;
        req_ch.from_owner_core = 1'b0;
        rsp_ch.ready           = 1'b0;
        mdl_ticks              = '0;
        mdl_total              = '0;
        mdl_idle               = '0;
        mdl_usage_on           = 1'b1;
        mismatch_count         = 0;
        send_idle_pct          = 6;
        recv_idle_pct          = 45;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, usage accounting on from reset.
        push_event(ttcu_pkg::OP_TICK, 32'd9, 1'b1, 1'b1);
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_TICK, '1, 1'b1, 1'b0);     // other core: no effect
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b0);
        push_event(ttcu_pkg::OP_SAMPLE, '1, 1'b1, 1'b1);   // half busy
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b0); // empty window
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b1, 1'b1);
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b1, 1'b1);
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1); // one third busy
        push_event(ttcu_pkg::OP_ANNOUNCE, 32'd0, 1'b0, 1'b0);
        push_event(ttcu_pkg::OP_ANNOUNCE, 32'd5, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b1, 1'b0); // slept ticks count as idle
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_ANNOUNCE, '1, 1'b1, 1'b1); // total wraps below idle
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1); // fully busy
        push_event(OP_UNUSED, '1, 1'b1, 1'b1);
        push_event(ttcu_pkg::OP_ANNOUNCE, '1, 1'b0, 1'b0); // tick count wraps
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b0, 1'b1);
        write_usage_enable(1'b0);
        push_event(ttcu_pkg::OP_TICK, 32'd0, 1'b1, 1'b1);
        push_event(ttcu_pkg::OP_ANNOUNCE, 32'd7, 1'b0, 1'b1);
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1); // disabled: zero, window kept
        write_usage_enable(1'b1);
        push_event(ttcu_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1);

        // Random part: sender rarely idle, receiver often stalling.
        push_random(115);
        wait_drained();
        push_random(115);
        write_usage_enable(1'b0);
        push_random(230);

        // Sender often idle, receiver rarely stalling.
        wait_drained();
        send_idle_pct = 45;
        recv_idle_pct = 6;
        write_usage_enable(1'b1);
        push_random(230);
        write_usage_enable(1'b0);
        push_random(230);

        // Back to back on both sides.
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_usage_enable(1'b1);
        push_random(230);

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/ttcu_pkg.sv
hdl/ttcu_if.sv
hdl/ttcu_div.sv
hdl/tick_timebase_cpu_usage.sv
hdl/ttcu_checker.sv
test/tb.sv
